>>> rtl/tap_tempo_estimator_defines.svh
// Assertion macros shared by the tap tempo estimator RTL.
`ifndef TAP_TEMPO_ESTIMATOR_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TTE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tte_pkg.sv
// Shared constants and types for the tap tempo estimator.
package tte_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int GAP_W         = 16;
    localparam int PERIOD_W      = 31;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int N_W           = $clog2(HISTORY_DEPTH + 2);
    localparam int BEAT_W        = GAP_W + 1;
    localparam int X_W           = GAP_W + $clog2(HISTORY_DEPTH);
    localparam int SX_W          = X_W + $clog2(HISTORY_DEPTH);
    localparam int P_W           = 2 * X_W;
    localparam int SP_W          = P_W + $clog2(HISTORY_DEPTH);
    localparam int P1_W          = N_W + SP_W;
    localparam int P2_W          = 2 * SX_W;
    localparam int NUM_W         = P1_W + 1;
    localparam int DIV_W         = NUM_W - 1;
    localparam int STEP_W        = $clog2(DIV_W + 1);

    // APB register map
    localparam int ADDR_W        = 3;
    localparam logic [0:0] REG_RESET_GAP = 1'b0;

    localparam logic [GAP_W-1:0]    RESET_GAP_DEFAULT = GAP_W'(1500);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX        = {PERIOD_W{1'b1}};

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/tte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tte_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module tte_div
    import tte_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output div_stat_t         stat,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]  r_reg, r_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DIV_W-1:0]  d_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIV_W:0]    rs;

    // one shift-compare-subtract step
    always_comb begin
        rs = {r_reg, q_reg[DIV_W-1]};
        if (rs >= {1'b0, d_reg}) begin
            r_next = DIV_W'(rs - {1'b0, d_reg});
            q_next = {q_reg[DIV_W-2:0], 1'b1};
        end else begin
            r_next = rs[DIV_W-1:0];
            q_next = {q_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end else if (busy_reg) begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

>>> rtl/tap_tempo_estimator.sv
// Tap tempo estimator top level: history RAM, median search, regression sequencer.
//
//  channel  | direction | contents
//  s_       | in        | tdata: elapsed_ms; tuser: restart
//  m_       | out       | tdata: period_ms; tuser: from_history
//  APB      | in/out    | reset_gap_ms at byte address 0
//
// An arming tap is absorbed in idle with no result; a direct-gap tap goes to the
// output state, and its result is valid once the output register is free. A
// regression tap runs a median search over the history entries, one RAM read per
// cycle, then beat rounding of each entry through the serial divider, and the
// final products, slope division and output.
// Reset is synchronous and active low; the history RAM needs no clearing.
// A new tap is taken only in idle; a result waiting on m_tready holds the
// sequencer in its output state.
`include "tap_tempo_estimator_defines.svh"

module tap_tempo_estimator
    import tte_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input taps
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [30:0] elapsed_ms, [31] zero
    input  logic [0:0]        s_tuser,   // [0] restart
    // period results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [30:0] period_ms, [31] zero
    output logic [0:0]        m_tuser,   // [0] from_history
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_MED       = 13'b0000000000010,
        S_REG_ISSUE = 13'b0000000000100,
        S_REG_LOAD  = 13'b0000000001000,
        S_REG_DIV   = 13'b0000000010000,
        S_REG_MUL   = 13'b0000000100000,
        S_REG_ACC   = 13'b0000001000000,
        S_FIN_A     = 13'b0000010000000,
        S_FIN_B     = 13'b0000100000000,
        S_FIN_C     = 13'b0001000000000,
        S_FIN_D     = 13'b0010000000000,
        S_FIN_DIV   = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } state_t;

    state_t               state_reg;
    logic                 armed_reg;
    logic [GAP_W-1:0]     reset_gap_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [HIST_AW-1:0]   head_reg;

    // median search
    logic [CNT_W-1:0]     cand_idx_reg;
    logic [N_W-1:0]       k_reg, kd_reg;
    logic                 rv_reg;
    logic [CNT_W-1:0]     lt_reg, le_reg;
    logic [GAP_W-1:0]     cand_reg, m_reg;

    // regression sums
    logic [CNT_W-1:0]     i_reg;
    logic [GAP_W-1:0]     g_reg;
    logic [X_W-1:0]       x_reg, y_reg;
    logic [SX_W-1:0]      sx_reg, sy_reg;
    logic [P_W-1:0]       pxx_reg, pxy_reg;
    logic [SP_W-1:0]      sxx_reg, sxy_reg;
    logic [P1_W-1:0]      p1_reg;
    logic [P2_W-1:0]      p2_reg;
    logic signed [NUM_W-1:0] num_reg, den_reg;

    // result and output registers
    logic [PERIOD_W-1:0]  res_period_reg;
    logic                 res_hist_reg;
    logic                 m_tvalid_reg;
    logic [PERIOD_W-1:0]  m_period_reg;
    logic                 m_hist_reg;

    // RAM and divider hookup
    logic                 ram_we;
    logic [HIST_AW-1:0]   ram_waddr, ram_raddr;
    logic [GAP_W-1:0]     ram_rdata;
    logic [HIST_AW-1:0]   lidx;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend, div_divisor;
    logic [STEP_W-1:0]    div_steps;
    div_stat_t            div_stat;
    logic [DIV_W-1:0]     div_quot;

    // misc combinational
    logic                 s_acc;
    logic                 cfg_wr;
    logic                 gap_over;
    logic                 hist_full;
    logic [N_W-1:0]       n_val;
    logic [CNT_W-1:0]     half;
    logic [CNT_W-1:0]     lt_n, le_n;
    logic                 med_issue;
    logic [BEAT_W-1:0]    beat_num;
    logic [X_W-1:0]       x_new, y_new;
    logic signed [NUM_W-1:0] diff;
    logic                 out_free;

    // logical history index to RAM address, wrapping at the depth
    function automatic logic [HIST_AW-1:0] phys_addr(input logic [HIST_AW-1:0] head,
                                                     input logic [HIST_AW-1:0] idx);
        logic [HIST_AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (HIST_AW+1)'(HISTORY_DEPTH)) begin
            sum = sum - (HIST_AW+1)'(HISTORY_DEPTH);
        end
        return sum[HIST_AW-1:0];
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign gap_over = s_tdata[PERIOD_W-1:0] > {{(PERIOD_W-GAP_W){1'b0}}, reset_gap_reg};
    assign hist_full = (count_reg == CNT_W'(HISTORY_DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[ADDR_W-1:2] == REG_RESET_GAP) ? {16'b0, reset_gap_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_gap_reg <= RESET_GAP_DEFAULT;
        end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_RESET_GAP) begin
            reset_gap_reg <= pwdata[GAP_W-1:0];
        end
    end

    // history append on an accepted gap
    assign ram_we    = s_acc && armed_reg && !s_tuser[0] && !gap_over;
    assign ram_waddr = hist_full ? head_reg : phys_addr(head_reg, count_reg[HIST_AW-1:0]);

    // read address select
    always_comb begin
        case (state_reg)
            S_MED: begin
                if (k_reg == '0) begin
                    lidx = cand_idx_reg[HIST_AW-1:0];
                end else begin
                    lidx = HIST_AW'(k_reg - 1'b1);
                end
            end
            S_REG_ISSUE: lidx = i_reg[HIST_AW-1:0];
            default:     lidx = '0;
        endcase
    end
    assign ram_raddr = phys_addr(head_reg, lidx);

    tte_ram #(
        .WIDTH (GAP_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[GAP_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // median search: rank of each candidate against all entries
    assign half      = count_reg >> 1;
    assign med_issue = ({1'b0, k_reg} <= (N_W+1)'(count_reg));
    assign lt_n      = lt_reg + CNT_W'(ram_rdata < cand_reg);
    assign le_n      = le_reg + CNT_W'(ram_rdata <= cand_reg);

    // beat rounding and running sums
    assign beat_num = BEAT_W'(m_reg >> 1) + BEAT_W'(ram_rdata);
    assign x_new    = x_reg + X_W'(div_quot[BEAT_W-1:0]);
    assign y_new    = y_reg + X_W'(g_reg);
    assign n_val    = N_W'(count_reg) + 1'b1;
    assign diff     = $signed({1'b0, p1_reg}) - $signed(NUM_W'(p2_reg));

    // divider requests
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
        case (state_reg)
            S_REG_LOAD: begin
                div_start    = 1'b1;
                div_dividend = {beat_num, {(DIV_W-BEAT_W){1'b0}}};
                div_divisor  = DIV_W'(m_reg);
                div_steps    = STEP_W'(BEAT_W);
            end
            S_FIN_D: begin
                div_start    = !(num_reg <= 0 || den_reg <= 0);
                div_dividend = num_reg[DIV_W-1:0];
                div_divisor  = den_reg[DIV_W-1:0];
                div_steps    = STEP_W'(DIV_W);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tte_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            armed_reg    <= 1'b0;
            count_reg    <= '0;
            head_reg     <= '0;
            rv_reg       <= 1'b0;
            k_reg        <= '0;
            kd_reg       <= '0;
            cand_idx_reg <= '0;
            lt_reg       <= '0;
            le_reg       <= '0;
            i_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output state reloads the register itself
            if (m_tvalid_reg && m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        if (!armed_reg || s_tuser[0]) begin
                            armed_reg <= 1'b1;
                        end else if (gap_over) begin
                            count_reg      <= '0;
                            res_period_reg <= s_tdata[PERIOD_W-1:0];
                            res_hist_reg   <= 1'b0;
                            state_reg      <= S_EMIT;
                        end else begin
                            if (hist_full) begin
                                head_reg <= (head_reg == HIST_AW'(HISTORY_DEPTH - 1)) ?
                                            '0 : head_reg + 1'b1;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                            end
                            cand_idx_reg <= '0;
                            k_reg        <= '0;
                            rv_reg       <= 1'b0;
                            lt_reg       <= '0;
                            le_reg       <= '0;
                            state_reg    <= S_MED;
                        end
                    end
                end
                S_MED: begin
                    rv_reg <= med_issue;
                    kd_reg <= k_reg;
                    if (med_issue) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (rv_reg) begin
                        if (kd_reg == '0) begin
                            cand_reg <= ram_rdata;
                        end else begin
                            lt_reg <= lt_n;
                            le_reg <= le_n;
                        end
                        if (kd_reg == N_W'(count_reg)) begin
                            if (lt_n <= half && half < le_n) begin
                                m_reg     <= (cand_reg == '0) ? GAP_W'(1) : cand_reg;
                                i_reg     <= '0;
                                x_reg     <= '0;
                                y_reg     <= '0;
                                sx_reg    <= '0;
                                sy_reg    <= '0;
                                sxx_reg   <= '0;
                                sxy_reg   <= '0;
                                state_reg <= S_REG_ISSUE;
                            end else begin
                                cand_idx_reg <= cand_idx_reg + 1'b1;
                                k_reg        <= '0;
                                lt_reg       <= '0;
                                le_reg       <= '0;
                            end
                        end
                    end
                end
                S_REG_ISSUE: begin
                    state_reg <= S_REG_LOAD;
                end
                S_REG_LOAD: begin
                    g_reg     <= ram_rdata;
                    state_reg <= S_REG_DIV;
                end
                S_REG_DIV: begin
                    if (div_stat.done) begin
                        x_reg     <= x_new;
                        y_reg     <= y_new;
                        sx_reg    <= sx_reg + SX_W'(x_new);
                        sy_reg    <= sy_reg + SX_W'(y_new);
                        state_reg <= S_REG_MUL;
                    end
                end
                S_REG_MUL: begin
                    pxx_reg   <= x_reg * x_reg;
                    pxy_reg   <= x_reg * y_reg;
                    state_reg <= S_REG_ACC;
                end
                S_REG_ACC: begin
                    sxx_reg <= sxx_reg + SP_W'(pxx_reg);
                    sxy_reg <= sxy_reg + SP_W'(pxy_reg);
                    i_reg   <= i_reg + 1'b1;
                    if (i_reg + 1'b1 == count_reg) begin
                        state_reg <= S_FIN_A;
                    end else begin
                        state_reg <= S_REG_ISSUE;
                    end
                end
                S_FIN_A: begin
                    p1_reg    <= n_val * sxy_reg;
                    p2_reg    <= sx_reg * sy_reg;
                    state_reg <= S_FIN_B;
                end
                S_FIN_B: begin
                    num_reg   <= diff;
                    p1_reg    <= n_val * sxx_reg;
                    p2_reg    <= sx_reg * sx_reg;
                    state_reg <= S_FIN_C;
                end
                S_FIN_C: begin
                    den_reg   <= diff;
                    state_reg <= S_FIN_D;
                end
                S_FIN_D: begin
                    res_hist_reg <= 1'b1;
                    if (num_reg <= 0 || den_reg <= 0) begin
                        res_period_reg <= '0;
                        state_reg      <= S_EMIT;
                    end else begin
                        state_reg <= S_FIN_DIV;
                    end
                end
                S_FIN_DIV: begin
                    if (div_stat.done) begin
                        // saturate the slope to the period range
                        res_period_reg <= (|div_quot[DIV_W-1:PERIOD_W]) ?
                                          PERIOD_MAX : div_quot[PERIOD_W-1:0];
                        state_reg      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_period_reg <= res_period_reg;
                        m_hist_reg   <= res_hist_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_period_reg};
    assign m_tuser  = m_hist_reg;

    // checks
    `TTE_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(HISTORY_DEPTH),
        "history count overflow")
    `TTE_ASSERT_ALWAYS(a_div_done_state,
        !div_stat.done || state_reg == S_REG_DIV || state_reg == S_FIN_DIV,
        "divider done outside a wait state")
    `TTE_ASSERT_NEXT(a_direct_gap, s_acc && armed_reg && !s_tuser[0] && gap_over,
        state_reg == S_EMIT, "direct gap did not go to output")
    `TTE_ASSERT_NEXT(a_emit_hold, state_reg == S_EMIT && m_tvalid_reg && !m_tready,
        state_reg == S_EMIT && m_tvalid_reg, "result overwrote a pending transaction")

endmodule
